// ===== hdl/rtph_pkg.sv =====
package rtph_pkg;

  typedef enum logic [2:0] {
    ACT_PUT      = 3'd0,
    ACT_PUT_RTP  = 3'd1,
    ACT_GET      = 3'd2,
    ACT_MARK     = 3'd3,
    ACT_EXPIRE   = 3'd4,
    ACT_CLEAR    = 3'd5,
    ACT_SIZE     = 3'd6,
    ACT_NONE     = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_HDR   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    REG_MAX_ENTRIES = 1'b0,
    REG_MAX_AGE     = 1'b1
  } reg_e;

  // Sequencer states of the core.
  typedef enum logic [3:0] {
    S_IDLE, S_EXP_RD, S_EXP_CHK, S_FIND_RD, S_FIND_CHK, S_WRITE,
    S_TRIM, S_MARK, S_OUT
  } state_e;

  // One stored descriptor.
  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] handle;
    logic [15:0] length;
    logic [47:0] stored_time;
    logic [47:0] retx_time;
    logic [15:0] retx_count;
  } entry_t;

  localparam int unsigned RtpMinLen  = 12;
  localparam logic [1:0]  RtpVersion = 2'd2;

endpackage

// ===== hdl/rtph_store.sv =====
// Descriptor memory: one write port, one registered read port.
module rtph_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  rtph_pkg::entry_t        wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output rtph_pkg::entry_t        rdata_o
);

  rtph_pkg::entry_t mem [DEPTH];

  // Write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/rtp_retransmit_history_table_core.sv =====
// Sequence per request: put/put_rtp expire aged entries from the head, scan the slots for a
// matching seq, write the entry (in place on a hit) and trim to max_entries; get/mark scan and
// then return (for mark, after updating) the entry; remove_expired only expires; other actions
// go straight to the result. Expiry and scan read one slot at a time through the single memory
// read port. One request at a time: ready returns the cycle after the result is taken.
// Reset: empty ring, head zero, max_entries 256, max_age_ms 1000; memory is not cleared.
module rtp_retransmit_history_table_core #(
  parameter int unsigned DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // action, seq, header_word, buffer_handle, packet_length, now_ms (lowest first)
  input  logic [151:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // status, seq_out, handle_out, length_out, stored_time_out, retx_time_out,
  // retx_count_out, entry_count (lowest first)
  output logic [191:0]  m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rtph_pkg::state_e state_q, state_d;

  logic [8:0]  max_entries_q;
  logic [31:0] max_age_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;

  // latched request
  logic [2:0]  act_q;
  logic [15:0] seq_q;
  logic [31:0] hw_q, handle_q;
  logic [15:0] len_q;
  logic [47:0] now_q;
  logic        found_q, found_d;
  logic [AW-1:0] fpos_q, fpos_d;

  logic [191:0] out_q, out_d;
  logic          ovalid_q, ovalid_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  rtph_pkg::entry_t wdata, rdata;

  rtph_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Ring position wrap; i never exceeds DEPTH, so one subtract is enough
  function automatic logic [AW-1:0] ring_pos(logic [AW-1:0] h, logic [CW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(i);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [CW-1:0] lim;
  logic [47:0]   age;
  logic [15:0]   put_seq;
  logic          is_rtp;

  always_comb begin
    if ({23'd0, max_entries_q} < 32'(DEPTH)) lim = CW'(max_entries_q);
    else lim = CW'(DEPTH);
    age     = now_q - rdata.stored_time;
    is_rtp  = (act_q == rtph_pkg::ACT_PUT_RTP);
    put_seq = is_rtp ? hw_q[23:8] : seq_q;
  end

  assign s_axis_tready = (state_q == rtph_pkg::S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= 9'd256;
      max_age_q     <= 32'd1000;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rtph_pkg::REG_MAX_ENTRIES) max_entries_q <= cfg_wdata_i[8:0];
      else max_age_q <= cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rtph_pkg::S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    found_q <= found_d;
    fpos_q  <= fpos_d;
    out_q   <= out_d;
    if (s_axis_tvalid && s_axis_tready) begin
      act_q    <= s_axis_tdata[2:0];
      seq_q    <= s_axis_tdata[18:3];
      hw_q     <= s_axis_tdata[50:19];
      handle_q <= s_axis_tdata[82:51];
      len_q    <= s_axis_tdata[98:83];
      now_q    <= s_axis_tdata[146:99];
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    found_d  = found_q;
    fpos_d   = fpos_q;
    out_d    = out_q;
    ovalid_d = ovalid_q;
    we       = 1'b0;
    waddr    = fpos_q;
    raddr    = ring_pos(head_q, idx_q);
    wdata    = rdata;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    unique case (state_q)
      rtph_pkg::S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = rtph_pkg::S_OUT;
          out_d   = '0;
          unique case (rtph_pkg::action_e'(s_axis_tdata[2:0]))
            rtph_pkg::ACT_PUT: begin
              if (s_axis_tdata[98:83] == 16'd0) begin
                out_d[1:0]  = rtph_pkg::ST_EMPTY;
                out_d[17:2] = s_axis_tdata[18:3];
              end else state_d = rtph_pkg::S_EXP_RD;
            end
            rtph_pkg::ACT_PUT_RTP: begin
              if (s_axis_tdata[98:83] < 16'(rtph_pkg::RtpMinLen) ||
                  s_axis_tdata[50:49] != rtph_pkg::RtpVersion)
                out_d[1:0] = rtph_pkg::ST_BAD_HDR;
              else state_d = rtph_pkg::S_EXP_RD;
            end
            rtph_pkg::ACT_GET, rtph_pkg::ACT_MARK: begin
              state_d = rtph_pkg::S_FIND_RD;
              idx_d   = '0;
              found_d = 1'b0;
            end
            rtph_pkg::ACT_EXPIRE: state_d = rtph_pkg::S_EXP_RD;
            rtph_pkg::ACT_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      rtph_pkg::S_EXP_RD: begin
        raddr = head_q;
        if (count_q == '0) begin
          state_d = rtph_pkg::S_FIND_RD;
          idx_d   = '0;
          found_d = 1'b0;
        end else state_d = rtph_pkg::S_EXP_CHK;
      end
      rtph_pkg::S_EXP_CHK: begin
        if (now_q >= rdata.stored_time && age > {16'd0, max_age_q}) begin
          head_d  = ring_pos(head_q, CW'(1));
          count_d = count_q - CW'(1);
          state_d = rtph_pkg::S_EXP_RD;
        end else begin
          state_d = rtph_pkg::S_FIND_RD;
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      rtph_pkg::S_FIND_RD: begin
        if (act_q == rtph_pkg::ACT_EXPIRE) state_d = rtph_pkg::S_OUT;
        else if (idx_q >= count_q) state_d = rtph_pkg::S_WRITE;
        else state_d = rtph_pkg::S_FIND_CHK;
      end
      rtph_pkg::S_FIND_CHK: begin
        fpos_d = ring_pos(head_q, idx_q);
        if (rdata.seq == ((act_q == rtph_pkg::ACT_PUT || is_rtp) ? put_seq : seq_q)) begin
          found_d = 1'b1;
          state_d = rtph_pkg::S_WRITE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = rtph_pkg::S_FIND_RD;
        end
      end
      rtph_pkg::S_WRITE: begin
        if (act_q == rtph_pkg::ACT_PUT || is_rtp) begin
          wdata.seq         = put_seq;
          wdata.handle      = handle_q;
          wdata.length      = len_q;
          wdata.stored_time = now_q;
          wdata.retx_time   = '0;
          wdata.retx_count  = '0;
          we = 1'b1;
          if (!found_q) begin
            if (count_q >= CW'(DEPTH)) begin
              head_d  = ring_pos(head_q, CW'(1));
              waddr   = ring_pos(head_q, count_q);
            end else begin
              waddr   = ring_pos(head_q, count_q);
              count_d = count_q + CW'(1);
            end
          end
          out_d = '0;
          out_d[17:2]    = put_seq;
          out_d[49:18]   = handle_q;
          out_d[65:50]   = len_q;
          out_d[113:66]  = now_q;
          state_d = rtph_pkg::S_TRIM;
        end else if (!found_q) begin
          out_d = '0;
          out_d[1:0]  = rtph_pkg::ST_NOT_FOUND;
          out_d[17:2] = seq_q;
          state_d = rtph_pkg::S_OUT;
        end else state_d = rtph_pkg::S_MARK;
      end
      rtph_pkg::S_MARK: begin
        wdata = rdata;
        if (act_q == rtph_pkg::ACT_MARK) begin
          we = 1'b1;
          wdata.retx_time = now_q;
          if (rdata.retx_count != 16'hFFFF) wdata.retx_count = rdata.retx_count + 16'd1;
        end
        out_d = '0;
        out_d[17:2]    = wdata.seq;
        out_d[49:18]   = wdata.handle;
        out_d[65:50]   = wdata.length;
        out_d[113:66]  = wdata.stored_time;
        out_d[161:114] = wdata.retx_time;
        out_d[177:162] = wdata.retx_count;
        state_d = rtph_pkg::S_OUT;
      end
      rtph_pkg::S_TRIM: begin
        if (count_q > lim) begin
          head_d  = ring_pos(head_q, CW'(1));
          count_d = count_q - CW'(1);
        end else state_d = rtph_pkg::S_OUT;
      end
      rtph_pkg::S_OUT: begin
        out_d[186:178] = 9'(count_q);
        ovalid_d = 1'b1;
        state_d  = rtph_pkg::S_IDLE;
      end
      default: state_d = rtph_pkg::S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("ring count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == rtph_pkg::S_IDLE) else $error("ready while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rtph_pkg::S_OUT |=> m_axis_tvalid) else $error("result missing");

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned Slots    = 256;
  localparam int unsigned IdleMax  = 6000;
  localparam int unsigned Settle   = 4;
  localparam int unsigned ExpSlots = 16;

  // One request and one result, in field terms.
  typedef struct {
    rtph_pkg::action_e action;
    logic [15:0] seq;
    logic [31:0] hdr;
    logic [31:0] handle;
    logic [15:0] len;
    logic [47:0] now;
  } req_t;

  typedef struct {
    rtph_pkg::status_e status;
    logic [15:0] seq;
    logic [31:0] handle;
    logic [15:0] len;
    logic [47:0] stored;
    logic [47:0] retx_time;
    logic [15:0] retx_count;
    logic [8:0]  count;
  } rsp_t;

  // Directed row: request plus an optional typed status and count.
  typedef struct {
    req_t        rq;
    bit          typed;
    rtph_pkg::status_e status;
    logic [8:0]  count;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [151:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;

  rtp_retransmit_history_table_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // History table mirror
  logic [15:0] h_seq     [Slots];
  logic [31:0] h_handle  [Slots];
  logic [15:0] h_len     [Slots];
  logic [47:0] h_stored  [Slots];
  logic [47:0] h_rtime   [Slots];
  logic [15:0] h_rcount  [Slots];
  int unsigned h_head, h_count;
  logic [8:0]  lim_entries = 9'd256;
  logic [31:0] lim_age = 32'd1000;

  // Expected results, oldest at exp_rd
  rsp_t        exp_buf [ExpSlots];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int unsigned errors;
  int unsigned cyc;
  int unsigned idle_cyc;
  logic [47:0] clock_ms;

  task automatic drop_oldest();
    if (h_count > 0) begin
      h_head = (h_head + 1) % Slots;
      h_count--;
    end
  endtask

  task automatic age_out(input logic [47:0] now);
    logic [47:0] t;
    while (h_count > 0) begin
      t = h_stored[h_head];
      if (now < t) break;
      if (now - t <= {16'd0, lim_age}) break;
      drop_oldest();
    end
  endtask

  function automatic int lookup(input logic [15:0] s);
    int unsigned p;
    for (int unsigned i = 0; i < h_count; i++) begin
      p = (h_head + i) % Slots;
      if (h_seq[p] == s) return int'(p);
    end
    return -1;
  endfunction

  task automatic store_entry(input req_t rq, input logic [15:0] s, inout rsp_t r);
    int f;
    int unsigned p, cap;
    cap = (lim_entries < Slots) ? lim_entries : Slots;
    age_out(rq.now);
    f = lookup(s);
    if (f >= 0) p = unsigned'(f);
    else begin
      if (h_count >= Slots) drop_oldest();
      p = (h_head + h_count) % Slots;
      h_count++;
    end
    h_seq[p] = s; h_handle[p] = rq.handle; h_len[p] = rq.len;
    h_stored[p] = rq.now; h_rtime[p] = '0; h_rcount[p] = '0;
    r.seq = s; r.handle = rq.handle; r.len = rq.len; r.stored = rq.now;
    while (h_count > cap) drop_oldest();
  endtask

  task automatic predict_history(input req_t rq, output rsp_t r);
    int f;
    r = '{rtph_pkg::ST_OK, '0, '0, '0, '0, '0, '0, '0};
    case (rq.action)
      rtph_pkg::ACT_PUT: begin
        if (rq.len == 0) begin
          r.status = rtph_pkg::ST_EMPTY;
          r.seq = rq.seq;
        end else store_entry(rq, rq.seq, r);
      end
      rtph_pkg::ACT_PUT_RTP: begin
        if (rq.len < rtph_pkg::RtpMinLen || rq.hdr[31:30] != rtph_pkg::RtpVersion)
          r.status = rtph_pkg::ST_BAD_HDR;
        else store_entry(rq, rq.hdr[23:8], r);
      end
      rtph_pkg::ACT_GET, rtph_pkg::ACT_MARK: begin
        f = lookup(rq.seq);
        if (f < 0) begin
          r.status = rtph_pkg::ST_NOT_FOUND;
          r.seq = rq.seq;
        end else begin
          if (rq.action == rtph_pkg::ACT_MARK) begin
            h_rtime[f] = rq.now;
            if (h_rcount[f] != 16'hFFFF) h_rcount[f]++;
          end
          r.seq = h_seq[f]; r.handle = h_handle[f]; r.len = h_len[f];
          r.stored = h_stored[f]; r.retx_time = h_rtime[f]; r.retx_count = h_rcount[f];
        end
      end
      rtph_pkg::ACT_EXPIRE: age_out(rq.now);
      rtph_pkg::ACT_CLEAR: begin
        h_head = 0;
        h_count = 0;
      end
      default: ;
    endcase
    r.count = h_count[8:0];
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0s: got %0h expected %0h at cycle %0d", what, got, want, cyc);
    errors++;
  endtask

  // Hold the request until accepted, then record its expected result.
  task automatic send_request(input req_t rq, input bit typed = 0,
                              input rtph_pkg::status_e st = rtph_pkg::ST_OK,
                              input logic [8:0] cnt = '0);
    rsp_t r;
    s_axis_tdata <= {5'd0, rq.now, rq.len, rq.handle, rq.hdr, rq.seq, rq.action};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_history(rq, r);
    if (typed) begin
      r.status = st;
      r.count = cnt;
    end
    exp_buf[exp_wr % ExpSlots] = r;
    exp_wr++;
    @(negedge clk_i);
    // Random idle between requests, none in the quiet window
    if (!(cyc > 3000 && cyc < 9000) && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input rtph_pkg::reg_e idx, input logic [31:0] val);
    while (exp_wr != exp_rd) @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (Settle) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rtph_pkg::REG_MAX_ENTRIES) lim_entries = val[8:0];
    else lim_age = val;
  endtask

  function automatic req_t random_request(input logic [15:0] seq_base, input int seq_span);
    req_t rq;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) clock_ms = clock_ms - 48'($urandom_range(1, 3000));
    else if (pick < 10) clock_ms = clock_ms + 48'($urandom_range(1000, 5000));
    else clock_ms = clock_ms + 48'($urandom_range(0, 120));
    rq.now = clock_ms;
    if ($urandom_range(99) < 3) rq.now = {$urandom, 16'($urandom)};
    rq.seq = seq_base + 16'($urandom_range(seq_span));
    if ($urandom_range(99) < 5) rq.seq = 16'($urandom);
    rq.handle = $urandom;
    rq.len = ($urandom_range(99) < 8) ? 16'($urandom_range(15)) : 16'($urandom);
    rq.hdr = {2'b10, 6'($urandom), rq.seq, 8'($urandom)};
    if ($urandom_range(99) < 10) rq.hdr = $urandom;
    pick = $urandom_range(99);
    if (pick < 35) rq.action = rtph_pkg::ACT_PUT;
    else if (pick < 50) rq.action = rtph_pkg::ACT_PUT_RTP;
    else if (pick < 70) rq.action = rtph_pkg::ACT_GET;
    else if (pick < 87) rq.action = rtph_pkg::ACT_MARK;
    else if (pick < 93) rq.action = rtph_pkg::ACT_EXPIRE;
    else if (pick < 95) rq.action = rtph_pkg::ACT_CLEAR;
    else if (pick < 98) rq.action = rtph_pkg::ACT_SIZE;
    else rq.action = rtph_pkg::ACT_NONE;
    return rq;
  endfunction

  // Result ready with random stalls, steady in the quiet window
  always @(negedge clk_i) begin
    cyc <= cyc + 1;
    m_axis_tready <= (cyc > 3000 && cyc < 9000) || ($urandom_range(99) >= 10);
  end

  // Compare each result with the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin
    rsp_t w;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > IdleMax) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_wr == exp_rd) report_mismatch("unexpected result", 64'd1, 64'd0);
      else begin
        w = exp_buf[exp_rd % ExpSlots];
        exp_rd++;
        if (m_axis_tdata[1:0] != w.status)
          report_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(w.status));
        if (m_axis_tdata[17:2] != w.seq)
          report_mismatch("seq", 64'(m_axis_tdata[17:2]), 64'(w.seq));
        if (m_axis_tdata[49:18] != w.handle)
          report_mismatch("handle", 64'(m_axis_tdata[49:18]), 64'(w.handle));
        if (m_axis_tdata[65:50] != w.len)
          report_mismatch("length", 64'(m_axis_tdata[65:50]), 64'(w.len));
        if (m_axis_tdata[113:66] != w.stored)
          report_mismatch("stored time", 64'(m_axis_tdata[113:66]), 64'(w.stored));
        if (m_axis_tdata[161:114] != w.retx_time)
          report_mismatch("retx time", 64'(m_axis_tdata[161:114]), 64'(w.retx_time));
        if (m_axis_tdata[177:162] != w.retx_count)
          report_mismatch("retx count", 64'(m_axis_tdata[177:162]), 64'(w.retx_count));
        if (m_axis_tdata[186:178] != w.count)
          report_mismatch("entry count", 64'(m_axis_tdata[186:178]), 64'(w.count));
      end
    end
  end

  initial begin
    row_t        rows[$];
    logic [47:0] big_t;
    logic [8:0]  ent_set[6];
    logic [31:0] age_set[6];
    big_t = 48'hFFFF_FFFF_FFFF;
    ent_set = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd7, 9'd256};
    age_set = '{32'hFFFF_FFFF, 32'd0, 32'd50, 32'd1000, 32'd400, 32'hFFFF_FFFF};
    h_head = 0;
    h_count = 0;
    clock_ms = 48'd5000;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty, bad header, missing entry, extremes, every action
    rows = '{
      '{'{rtph_pkg::ACT_SIZE, 16'd0, 32'd0, 32'd0, 16'd0, 48'd0},
        1, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_GET, 16'd5, 32'd0, 32'd0, 16'd0, 48'd0},
        1, rtph_pkg::ST_NOT_FOUND, 9'd0},
      '{'{rtph_pkg::ACT_MARK, 16'hFFFF, 32'd0, 32'd0, 16'd0, 48'd0},
        1, rtph_pkg::ST_NOT_FOUND, 9'd0},
      '{'{rtph_pkg::ACT_PUT, 16'd9, 32'd0, 32'hFFFF_FFFF, 16'd0, 48'd10},
        1, rtph_pkg::ST_EMPTY, 9'd0},
      '{'{rtph_pkg::ACT_PUT_RTP, 16'd0, 32'h8012_3400, 32'd1, 16'd11, 48'd10},
        1, rtph_pkg::ST_BAD_HDR, 9'd0},
      '{'{rtph_pkg::ACT_PUT_RTP, 16'd0, 32'h4012_3400, 32'd1, 16'd100, 48'd10},
        1, rtph_pkg::ST_BAD_HDR, 9'd0},
      '{'{rtph_pkg::ACT_PUT_RTP, 16'd0, 32'hC012_3400, 32'd1, 16'd100, 48'd10},
        1, rtph_pkg::ST_BAD_HDR, 9'd0},
      '{'{rtph_pkg::ACT_PUT, 16'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 48'd0},
        1, rtph_pkg::ST_OK, 9'd1},
      '{'{rtph_pkg::ACT_PUT, 16'hFFFF, 32'd0, 32'd0, 16'd1, 48'd100},
        1, rtph_pkg::ST_OK, 9'd2},
      '{'{rtph_pkg::ACT_PUT_RTP, 16'd0, 32'hBFAB_CDFF, 32'h1234_5678, 16'd12, 48'd200},
        1, rtph_pkg::ST_OK, 9'd3},
      '{'{rtph_pkg::ACT_MARK, 16'hFFFF, 32'd0, 32'd0, 16'd0, 48'd300},
        0, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_MARK, 16'hFFFF, 32'd0, 32'd0, 16'd0, big_t},
        0, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_GET, 16'hABCD, 32'd0, 32'd0, 16'd0, 48'd0},
        0, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_PUT, 16'd0, 32'd0, 32'hAAAA_5555, 16'd77, 48'd400},
        1, rtph_pkg::ST_OK, 9'd3},
      '{'{rtph_pkg::ACT_GET, 16'd0, 32'd0, 32'd0, 16'd0, 48'd0},
        0, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_EXPIRE, 16'd0, 32'd0, 32'd0, 16'd0, 48'd50},
        1, rtph_pkg::ST_OK, 9'd3},
      '{'{rtph_pkg::ACT_EXPIRE, 16'd0, 32'd0, 32'd0, 16'd0, 48'd1150},
        0, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_PUT, 16'd3, 32'd0, 32'd3, 16'd3, big_t},
        1, rtph_pkg::ST_OK, 9'd1},
      '{'{rtph_pkg::ACT_PUT, 16'd4, 32'd0, 32'd4, 16'd4, 48'd0},
        1, rtph_pkg::ST_OK, 9'd2},
      '{'{rtph_pkg::ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, big_t},
        1, rtph_pkg::ST_OK, 9'd2},
      '{'{rtph_pkg::ACT_CLEAR, 16'd0, 32'd0, 32'd0, 16'd0, 48'd0},
        1, rtph_pkg::ST_OK, 9'd0},
      '{'{rtph_pkg::ACT_SIZE, 16'd0, 32'd0, 32'd0, 16'd0, 48'd0},
        1, rtph_pkg::ST_OK, 9'd0}
    };
    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].status, rows[i].count);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rtph_pkg::REG_MAX_ENTRIES, {23'd0, ent_set[ph]});
      write_reg(rtph_pkg::REG_MAX_AGE, age_set[ph]);
      if (ph == 5) begin
        // Fill past the ring size with distinct numbers
        for (int k = 0; k < 280; k++) begin
          req_t rq;
          rq = '{rtph_pkg::ACT_PUT, 16'(k * 7 + 1000), 32'd0, $urandom,
                 16'($urandom_range(1, 65535)), clock_ms};
          send_request(rq);
        end
      end
      for (int k = 0; k < 150; k++) send_request(random_request(16'($urandom), 40));
    end

    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
